FILE: sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Character codes, status codes and the stack entry type shared by the
// checker modules and its channel interfaces.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_RUN       = 3'd0;
    localparam t_status ST_MISMATCH  = 3'd1;
    localparam t_status ST_UNMATCHED = 3'd2;
    localparam t_status ST_OVERFLOW  = 3'd3;
    localparam t_status ST_END_OK    = 3'd4;
    localparam t_status ST_END_OPEN  = 3'd5;

    // Quote modes
    typedef logic [1:0] t_quote;
    localparam t_quote QM_NONE   = 2'd0;
    localparam t_quote QM_SINGLE = 2'd1;
    localparam t_quote QM_DOUBLE = 2'd2;

    // Bracket kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ROUND  = 2'd0;
    localparam t_kind KIND_CURLY  = 2'd1;
    localparam t_kind KIND_SQUARE = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_OPEN_R = 8'h28;  // (
    localparam logic [7:0] CH_OPEN_C = 8'h7B;  // {
    localparam logic [7:0] CH_OPEN_S = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE_R = 8'h29; // )
    localparam logic [7:0] CH_CLOSE_C = 8'h7D; // }
    localparam logic [7:0] CH_CLOSE_S = 8'h5D; // ]

    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [15:0] LINE_ONE = 16'd1;

    // One stack entry: bracket kind and the line it opened on
    typedef struct packed {
        t_kind       kind;
        logic [15:0] line;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Map a bracket kind back to its opening character
    function automatic logic [7:0] opener_char(input t_kind kind);
        logic [7:0] ch;
        case (kind)
            KIND_ROUND:  ch = CH_OPEN_R;
            KIND_CURLY:  ch = CH_OPEN_C;
            KIND_SQUARE: ch = CH_OPEN_S;
            default:     ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

FILE: sv/bbc_in_if.sv
// ----------------------------------------------------------------------------
// Bracket balance checker input channel
// Valid/ready channel carrying one text byte and the end-of-stream flag.
// ----------------------------------------------------------------------------
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output byte_in, output last, input ready);
    modport sink   (input valid, input byte_in, input last, output ready);
endinterface

FILE: sv/bbc_out_if.sv
// ----------------------------------------------------------------------------
// Bracket balance checker output channel
// Valid/ready channel carrying one check result per input byte.
// ----------------------------------------------------------------------------
interface bbc_out_if;
    import bbc_pkg::*;

    logic        valid;
    logic        ready;
    t_status     status;
    logic [7:0]  bracket;
    logic [15:0] line_no;

    modport source (output valid, output status, output bracket, output line_no, input ready);
    modport sink   (input valid, input status, input bracket, input line_no, output ready);
endinterface

FILE: sv/bbc_stack.sv
// ----------------------------------------------------------------------------
// Bracket stack memory
// Single write port and one registered read port. The read data is
// presented in the cycle after the address is applied.
// ----------------------------------------------------------------------------
module bbc_stack #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(STACK_DEPTH)-1:0]  i_waddr,
    input  bbc_pkg::t_entry                 i_wdata,
    input  logic [$clog2(STACK_DEPTH)-1:0]  i_raddr,
    output bbc_pkg::t_entry                 o_rdata
);
    import bbc_pkg::*;

    t_entry r_mem [STACK_DEPTH];
    t_entry r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bracket_balance_checker.sv
// The result passes through the input register, then the result register.
// Throughput: one byte per cycle while the result channel is not stalled,
//   set by the push/pop against a cached top entry and a prefetched entry below.
// Reset (synchronous, active low) empties the stack, clears quote mode and
//   the halt flag and sets the line count to one; the stack memory is not cleared.
// ----------------------------------------------------------------------------
// Bracket balance checker
// Scans a byte stream, tracks bracket nesting with a stack of openers and
// their lines, skips quoted text and reports one status per byte.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbc_in_if.sink     i_in,
    bbc_out_if.source  o_out
);
    import bbc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);
    localparam logic [CW-1:0] COUNT_TWO  = CW'(2);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    // Checker state
    logic [CW-1:0] r_count;
    t_quote        r_quote;
    logic [15:0]   r_line;
    logic          r_halted;
    t_entry        r_top;

    // Result register
    logic        r_out_valid;
    t_status     r_status;
    logic [7:0]  r_bracket;
    logic [15:0] r_line_no;

    // Next-state values
    logic [CW-1:0] n_count;
    t_quote        n_quote;
    logic [15:0]   n_line;
    logic          n_halted;
    t_entry        n_top;
    t_status       n_status;
    logic [7:0]    n_bracket;
    logic [15:0]   n_line_no;

    logic        advance;
    logic        is_open;
    logic        is_close;
    t_kind       byte_kind;
    logic        push;
    t_entry      push_entry;
    t_entry      below;
    logic [CW-1:0] rd_count;
    logic [CW-1:0] rd_index;

    // Move an item from the input register into the result register
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.byte_in;
            r_last <= i_in.last;
        end
    end

    // Classify the byte
    always_comb begin
        is_open   = 1'b0;
        is_close  = 1'b0;
        byte_kind = KIND_ROUND;
        case (r_byte)
            CH_OPEN_R:  begin is_open  = 1'b1; byte_kind = KIND_ROUND;  end
            CH_OPEN_C:  begin is_open  = 1'b1; byte_kind = KIND_CURLY;  end
            CH_OPEN_S:  begin is_open  = 1'b1; byte_kind = KIND_SQUARE; end
            CH_CLOSE_R: begin is_close = 1'b1; byte_kind = KIND_ROUND;  end
            CH_CLOSE_C: begin is_close = 1'b1; byte_kind = KIND_CURLY;  end
            CH_CLOSE_S: begin is_close = 1'b1; byte_kind = KIND_SQUARE; end
            default: ;
        endcase
    end

    // Handle one byte: quotes, lines, push and pop, end of stream
    always_comb begin
        n_count    = r_count;
        n_quote    = r_quote;
        n_line     = r_line;
        n_halted   = r_halted;
        n_top      = r_top;
        n_status   = ST_RUN;
        n_bracket  = 8'd0;
        n_line_no  = 16'd0;
        push       = 1'b0;
        push_entry = '{kind: byte_kind, line: r_line};

        if (!r_halted) begin
            // Track quoted text
            case (r_quote)
                QM_NONE: begin
                    if (r_byte == CH_SQUOTE) begin
                        n_quote = QM_SINGLE;
                    end else if (r_byte == CH_DQUOTE) begin
                        n_quote = QM_DOUBLE;
                    end
                end
                QM_SINGLE: begin
                    if (r_byte == CH_SQUOTE) begin
                        n_quote = QM_NONE;
                    end
                end
                QM_DOUBLE: begin
                    if (r_byte == CH_DQUOTE) begin
                        n_quote = QM_NONE;
                    end
                end
                default: n_quote = QM_NONE;
            endcase

            // Count lines, saturating
            if (r_byte == CH_LF && r_line != LINE_MAX) begin
                n_line = r_line + 16'd1;
            end
            push_entry = '{kind: byte_kind, line: n_line};

            // Push an opener or pop on a closer
            if (n_quote == QM_NONE && is_open) begin
                if (r_count == COUNT_FULL) begin
                    n_status  = ST_OVERFLOW;
                    n_bracket = r_byte;
                    n_line_no = n_line;
                    n_halted  = 1'b1;
                end else begin
                    push    = 1'b1;
                    n_count = r_count + COUNT_ONE;
                    n_top   = push_entry;
                end
            end else if (n_quote == QM_NONE && is_close) begin
                if (r_count == '0) begin
                    n_status  = ST_UNMATCHED;
                    n_bracket = r_byte;
                    n_line_no = n_line;
                    n_halted  = 1'b1;
                end else begin
                    n_count = r_count - COUNT_ONE;
                    n_top   = below;
                    if (r_top.kind != byte_kind) begin
                        n_status  = ST_MISMATCH;
                        n_bracket = opener_char(r_top.kind);
                        n_line_no = r_top.line;
                        n_halted  = 1'b1;
                    end
                end
            end
        end

        // Close out the stream and return to reset values
        if (r_last) begin
            if (n_status == ST_RUN) begin
                if (r_halted) begin
                    n_status = ST_END_OPEN;
                end else if (n_count == '0) begin
                    n_status = ST_END_OK;
                end else begin
                    n_status  = ST_END_OPEN;
                    n_bracket = opener_char(n_top.kind);
                    n_line_no = n_top.line;
                end
            end
            n_count  = '0;
            n_quote  = QM_NONE;
            n_line   = LINE_ONE;
            n_halted = 1'b0;
        end
    end

    // Prefetch the entry just below the top for the next pop
    assign rd_count = advance ? n_count : r_count;
    assign rd_index = rd_count - COUNT_TWO;

    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (advance && push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (push_entry),
        .i_raddr (rd_index[AW-1:0]),
        .o_rdata (below)
    );

    // Update checker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_quote  <= QM_NONE;
            r_line   <= LINE_ONE;
            r_halted <= 1'b0;
        end else if (advance) begin
            r_count  <= n_count;
            r_quote  <= n_quote;
            r_line   <= n_line;
            r_halted <= n_halted;
        end
    end

    // Hold the cached top entry
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_top <= n_top;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status  <= n_status;
            r_bracket <= n_bracket;
            r_line_no <= n_line_no;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_status;
    assign o_out.bracket = r_bracket;
    assign o_out.line_no = r_line_no;

endmodule

FILE: tb/bracket_balance_checker_tb.sv
// ----------------------------------------------------------------------------
// Bracket balance checker testbench
// Drives byte streams through the input channel with random gaps, applies
// random backpressure on the result channel, and checks every result against
// a cycle-free scan predictor. Covers nesting, quoting, line counting,
// stack overflow, halting on errors and end-of-stream handling.
// ----------------------------------------------------------------------------
module bracket_balance_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int DEPTH = 128;

    typedef struct packed {
        t_status     status;
        logic [7:0]  bracket;
        logic [15:0] line_no;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbc_in_if  in_if ();
    bbc_out_if out_if ();

    bracket_balance_checker #(
        .STACK_DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Bracket characters indexed by kind
    logic [7:0] open_ch [3] = '{CH_OPEN_R, CH_OPEN_C, CH_OPEN_S};
    logic [7:0] close_ch[3] = '{CH_CLOSE_R, CH_CLOSE_C, CH_CLOSE_S};
    logic [7:0] soup_ch [10] = '{CH_OPEN_R, CH_OPEN_C, CH_OPEN_S, CH_CLOSE_R,
                                 CH_CLOSE_C, CH_CLOSE_S, CH_SQUOTE, CH_DQUOTE,
                                 CH_LF, 8'h61};

    // Predictor state
    t_entry      open_stack[DEPTH];
    int          open_depth;
    t_quote      quote_state;
    logic [15:0] line_ctr;
    bit          check_halted;

    t_result pending_results[$];
    int      fail_count;
    int      bytes_sent;
    bit      in_steady;
    bit      out_steady;
    int      stall_left;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Return the scan state to its post-reset values
    function automatic void reset_scan();
        open_depth   = 0;
        quote_state  = QM_NONE;
        line_ctr     = LINE_ONE;
        check_halted = 1'b0;
    endfunction

    // Advance the scan by one byte and return the result it produces
    function automatic t_result scan_byte(logic [7:0] ch, logic lst);
        t_result r;
        bit      was_halted;
        int      okind;
        int      ckind;
        t_entry  top;
        r          = '{ST_RUN, 8'd0, 16'd0};
        was_halted = check_halted;
        okind      = -1;
        ckind      = -1;
        for (int k = 0; k < 3; k++) begin
            if (ch == open_ch[k]) okind = k;
            if (ch == close_ch[k]) ckind = k;
        end
        if (!check_halted) begin
            // Track quoting; only the opening character closes a quote
            case (quote_state)
                QM_NONE: begin
                    if (ch == CH_SQUOTE) quote_state = QM_SINGLE;
                    else if (ch == CH_DQUOTE) quote_state = QM_DOUBLE;
                end
                QM_SINGLE: if (ch == CH_SQUOTE) quote_state = QM_NONE;
                QM_DOUBLE: if (ch == CH_DQUOTE) quote_state = QM_NONE;
                default:   quote_state = QM_NONE;
            endcase
            if (ch == CH_LF && line_ctr != LINE_MAX) line_ctr++;
            if (quote_state == QM_NONE && okind >= 0) begin
                if (open_depth >= DEPTH) begin
                    r = '{ST_OVERFLOW, ch, line_ctr};
                    check_halted = 1'b1;
                end else begin
                    open_stack[open_depth] = '{t_kind'(okind), line_ctr};
                    open_depth++;
                end
            end else if (quote_state == QM_NONE && ckind >= 0) begin
                if (open_depth == 0) begin
                    r = '{ST_UNMATCHED, ch, line_ctr};
                    check_halted = 1'b1;
                end else begin
                    open_depth--;
                    top = open_stack[open_depth];
                    if (top.kind != t_kind'(ckind)) begin
                        r = '{ST_MISMATCH, open_ch[top.kind], top.line};
                        check_halted = 1'b1;
                    end
                end
            end
        end
        if (lst) begin
            if (r.status == ST_RUN) begin
                if (was_halted) begin
                    r.status = ST_END_OPEN;
                end else if (open_depth == 0) begin
                    r.status = ST_END_OK;
                end else begin
                    top = open_stack[open_depth - 1];
                    r   = '{ST_END_OPEN, open_ch[top.kind], top.line};
                end
            end
            reset_scan();
        end
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Predict on each accepted byte, compare on each accepted result
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                pending_results.push_back(scan_byte(in_if.byte_in, in_if.last));
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.status, out_if.bracket, out_if.line_no};
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result status %0d bracket %h line %0d",
                                           got.status, got.bracket, got.line_no));
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.bracket !== want.bracket ||
                        got.line_no !== want.line_no)
                        note_failure($sformatf({"mismatch: status exp %0d got %0d, ",
                                                "bracket exp %h got %h, line exp %0d got %0d"},
                                               want.status, got.status, want.bracket,
                                               got.bracket, want.line_no, got.line_no));
                end
            end
        end
    end

    // Result backpressure: random stalls, with stretches of steady acceptance
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) out_steady = !out_steady;
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else if (!out_steady && $urandom_range(0, 4) == 0) begin
            out_if.ready <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(4, 19);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // Present one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] ch, input logic lst);
        int gap;
        if ($urandom_range(0, 99) == 0) in_steady = !in_steady;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.byte_in <= ch;
        in_if.last    <= lst;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send a string, marking its final byte as end of stream
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic test_balanced();
        send_text("({[a]})\n");
        send_text("x");
        send_text("[]{}()");
    endtask

    task automatic test_mismatch();
        // Error on the closer, then halted bytes, then the end reports unclosed
        send_text("(\n](}a");
        send_text("[{)");
    endtask

    task automatic test_unmatched();
        send_text(")(((");
        send_byte(CH_CLOSE_C, 1'b1);
        send_byte(CH_OPEN_R, 1'b1);
    endtask

    task automatic test_quotes();
        send_text("'(\"[\n'\"{'}\"x");
        send_text("(\"]\"'");
        send_text("\"(\n\n");
    endtask

    task automatic test_lines();
        send_text("\n\n[\n");
        send_text("a\n{\n\n)");
    endtask

    task automatic test_overflow();
        int kinds[$];
        int k;
        // Fill to the brim and end open
        for (int i = 0; i < DEPTH; i++) send_byte(open_ch[$urandom_range(0, 2)], 1'b0);
        send_byte(8'h62, 1'b1);
        // Fill to the brim and drain in order
        for (int i = 0; i < DEPTH; i++) begin
            k = $urandom_range(0, 2);
            kinds.push_back(k);
            send_byte(open_ch[k], 1'b0);
            if (i == DEPTH / 2) send_byte(CH_LF, 1'b0);
        end
        while (kinds.size() > 0) send_byte(close_ch[kinds.pop_back()], 1'b0);
        send_byte(CH_LF, 1'b1);
        // One push past full
        for (int i = 0; i < DEPTH; i++) send_byte(open_ch[$urandom_range(0, 2)], 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_OPEN_S, 1'b0);
        send_byte(CH_CLOSE_S, 1'b1);
    endtask

    task automatic test_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    // Mostly well-nested text with quotes and noise, occasionally broken
    task automatic send_nested_stream();
        int         open_kinds[$];
        int         len;
        int         r;
        int         k;
        logic [7:0] q;
        logic [7:0] ch;
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30 && open_kinds.size() < 24) begin
                k = $urandom_range(0, 2);
                open_kinds.push_back(k);
                send_byte(open_ch[k], 1'b0);
            end else if (r < 55 && open_kinds.size() > 0) begin
                k = open_kinds.pop_back();
                if ($urandom_range(0, 19) == 0) k = $urandom_range(0, 2);
                send_byte(close_ch[k], 1'b0);
            end else if (r < 63) begin
                send_byte(CH_LF, 1'b0);
            end else if (r < 70) begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                send_byte(q, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    ch = soup_ch[$urandom_range(0, 9)];
                    send_byte(ch == q ? 8'h61 : ch, 1'b0);
                end
                send_byte(q, 1'b0);
            end else if (r < 78) begin
                ch = 8'($urandom_range(0, 255));
                if (ch == CH_SQUOTE || ch == CH_DQUOTE) ch = 8'h20;
                send_byte(ch, 1'b0);
            end else begin
                send_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0)
            while (open_kinds.size() > 0) send_byte(close_ch[open_kinds.pop_back()], 1'b0);
        if ($urandom_range(0, 4) == 0) send_byte(soup_ch[$urandom_range(0, 9)], 1'b1);
        else send_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b1);
    endtask

    task automatic test_random();
        int target;
        int len;
        int mode;
        target = bytes_sent + 600;
        while (bytes_sent < target) begin
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                send_nested_stream();
            end else begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                    send_byte(mode == 9 ? 8'($urandom_range(0, 255))
                                        : soup_ch[$urandom_range(0, 9)], i == len - 1);
            end
        end
    endtask

    initial begin
        in_if.valid   = 1'b0;
        in_if.byte_in = 8'd0;
        in_if.last    = 1'b0;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        fail_count    = 0;
        bytes_sent    = 0;
        in_steady     = 1'b0;
        out_steady    = 1'b0;
        stall_left    = 0;
        reset_scan();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_balanced();
        test_mismatch();
        test_unmatched();
        test_quotes();
        test_lines();
        test_extremes();
        test_overflow();
        test_random();

        // Drain outstanding results, then let the pipeline settle
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bracket_balance_checker_tb passed");
        end else begin
            $display("bracket_balance_checker_tb failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #40ms;
        $display("bracket_balance_checker_tb failed");
        $finish;
    end

endmodule
